// ===== sv/assert_macros.svh =====
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Next-cycle implication, masked while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

// Next-cycle implication, checked during reset as well.
`define ASSERT_NEXT_NR(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("reset check failed");

`endif

// ===== sv/acbc_pkg.sv =====
// ----------------------------------------------------------------------------
// acbc_pkg
// Shared types, register codes and substitution tables for the AES-256 CBC
// decryption block.
// ----------------------------------------------------------------------------
package acbc_pkg;

    localparam int unsigned NumRounds = 14;
    localparam int unsigned RkIdxW    = 4;
    localparam int unsigned CfgIdxW   = 3;

    localparam logic [RkIdxW-1:0] LastRk = RkIdxW'(NumRounds);

    localparam logic [CfgIdxW-1:0] CfgKey0  = 3'd0;
    localparam logic [CfgIdxW-1:0] CfgKey1  = 3'd1;
    localparam logic [CfgIdxW-1:0] CfgKey2  = 3'd2;
    localparam logic [CfgIdxW-1:0] CfgKey3  = 3'd3;
    localparam logic [CfgIdxW-1:0] CfgIvHi  = 3'd4;
    localparam logic [CfgIdxW-1:0] CfgIvLo  = 3'd5;

    typedef enum logic [1:0] {
        ST_EXP_LOAD,
        ST_EXPAND,
        ST_IDLE,
        ST_ROUND
    } state_t;

    typedef struct packed {
        logic              exp_load;
        logic              exp_step;
        logic [RkIdxW-1:0] exp_idx;
        logic              blk_load;
        logic              rnd_step;
        logic [RkIdxW-1:0] rnd_idx;
        logic              out_load;
    } dp_cmd_t;

    localparam logic [7:0] FwdSbox [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,
        8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,
        8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,
        8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,
        8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,
        8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,
        8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,
        8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,
        8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,
        8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,
        8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,
        8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,
        8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,
        8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,
        8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,
        8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,
        8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    localparam logic [7:0] InvSbox [256] = '{
        8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,
        8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
        8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,
        8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
        8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,
        8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
        8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,
        8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
        8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,
        8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
        8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,
        8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
        8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,
        8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
        8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,
        8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
        8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,
        8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
        8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,
        8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
        8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,
        8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
        8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,
        8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
        8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,
        8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
        8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,
        8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
        8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,
        8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
        8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,
        8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
    };

endpackage

// ===== sv/acbc_ctrl.sv =====
// ----------------------------------------------------------------------------
// acbc_ctrl
// Sequencer: key expansion steps, block rounds and the result register.
// ----------------------------------------------------------------------------
module acbc_ctrl (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_valid,
    input  logic [acbc_pkg::CfgIdxW-1:0]    cfg_index,
    output logic                            cfg_ready,
    input  logic                            s_valid,
    output logic                            s_ready,
    output logic                            m_valid,
    input  logic                            m_ready,
    output acbc_pkg::dp_cmd_t               cmd
);

    acbc_pkg::state_t                 state_reg, state_next;
    logic [acbc_pkg::RkIdxW-1:0]      cnt_reg, cnt_next;
    logic                             out_valid_reg, out_valid_next;
    logic                             key_wr;

    assign cfg_ready = 1'b1;
    assign m_valid   = out_valid_reg;
    assign key_wr    = cfg_valid && (cfg_index <= acbc_pkg::CfgKey3);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= acbc_pkg::ST_EXP_LOAD;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        cmd            = '0;
        s_ready        = 1'b0;
        out_valid_next = out_valid_reg && !m_ready;
        unique case (state_reg)
            acbc_pkg::ST_EXP_LOAD: begin
                cmd.exp_load = 1'b1;
                cnt_next     = '0;
                state_next   = acbc_pkg::ST_EXPAND;
            end
            acbc_pkg::ST_EXPAND: begin
                cmd.exp_step = 1'b1;
                cmd.exp_idx  = cnt_reg;
                if (cnt_reg == acbc_pkg::LastRk) begin
                    state_next = acbc_pkg::ST_IDLE;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            acbc_pkg::ST_IDLE: begin
                s_ready     = 1'b1;
                cmd.rnd_idx = acbc_pkg::LastRk;
                if (s_valid) begin
                    cmd.blk_load = 1'b1;
                    cnt_next     = acbc_pkg::LastRk - 1'b1;
                    state_next   = acbc_pkg::ST_ROUND;
                end
            end
            acbc_pkg::ST_ROUND: begin
                cmd.rnd_idx = cnt_reg;
                if (cnt_reg != '0) begin
                    cmd.rnd_step = 1'b1;
                    cnt_next     = cnt_reg - 1'b1;
                end else if (!out_valid_reg || m_ready) begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = acbc_pkg::ST_IDLE;
                end
            end
            default: state_next = acbc_pkg::ST_EXP_LOAD;
        endcase
        // a new key restarts the expansion
        if (key_wr) begin
            state_next = acbc_pkg::ST_EXP_LOAD;
        end
    end

endmodule

// ===== sv/acbc_dp.sv =====
// ----------------------------------------------------------------------------
// acbc_dp
// Datapath: config registers, key schedule, round key store, inverse round.
// ----------------------------------------------------------------------------
module acbc_dp (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic [acbc_pkg::CfgIdxW-1:0]    cfg_index,
    input  logic [63:0]                     cfg_data,
    input  logic [63:0]                     s_cipher_high,
    input  logic [63:0]                     s_cipher_low,
    input  logic                            s_first_block,
    output logic [63:0]                     m_plain_high,
    output logic [63:0]                     m_plain_low,
    input  acbc_pkg::dp_cmd_t               cmd
);

    function automatic logic [7:0] xt(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [127:0] inv_shift_sub(input logic [127:0] s);
        logic [127:0] o;
        o = '0;
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                o[127 - 8 * ((((c + r) & 3) * 4) + r) -: 8] =
                    acbc_pkg::InvSbox[s[127 - 8 * (c * 4 + r) -: 8]];
            end
        end
        return o;
    endfunction

    function automatic logic [127:0] inv_mix(input logic [127:0] s);
        logic [127:0] o;
        logic [7:0]   a [4];
        logic [7:0]   x2 [4];
        logic [7:0]   x4 [4];
        logic [7:0]   x8 [4];
        logic [7:0]   m9 [4];
        logic [7:0]   m11 [4];
        logic [7:0]   m13 [4];
        logic [7:0]   m14 [4];
        o = '0;
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                a[r]   = s[127 - 8 * (c * 4 + r) -: 8];
                x2[r]  = xt(a[r]);
                x4[r]  = xt(x2[r]);
                x8[r]  = xt(x4[r]);
                m9[r]  = x8[r] ^ a[r];
                m11[r] = x8[r] ^ x2[r] ^ a[r];
                m13[r] = x8[r] ^ x4[r] ^ a[r];
                m14[r] = x8[r] ^ x4[r] ^ x2[r];
            end
            o[127 - 8 * (c * 4) -: 8]     = m14[0] ^ m11[1] ^ m13[2] ^ m9[3];
            o[127 - 8 * (c * 4 + 1) -: 8] = m9[0] ^ m14[1] ^ m11[2] ^ m13[3];
            o[127 - 8 * (c * 4 + 2) -: 8] = m13[0] ^ m9[1] ^ m14[2] ^ m11[3];
            o[127 - 8 * (c * 4 + 3) -: 8] = m11[0] ^ m13[1] ^ m9[2] ^ m14[3];
        end
        return o;
    endfunction

    logic [63:0]  key_reg [4];
    logic [63:0]  iv_hi_reg, iv_lo_reg;
    logic [127:0] prev_reg, chain_reg, blk_reg, plain_reg;
    logic [255:0] win_reg;
    logic [7:0]   rcon_reg;
    logic [127:0] rk_reg [acbc_pkg::NumRounds + 1];

    logic [127:0] rk, ak, mx;
    logic [31:0]  w7, tmp, n0, n1, n2, n3;
    logic         rot_step;

    // inverse round: shift, substitute, add key, then mix
    assign rk = rk_reg[cmd.rnd_idx];
    assign ak = inv_shift_sub(blk_reg) ^ rk;
    assign mx = inv_mix(ak);

    // next four schedule words from the eight-word window
    assign rot_step = !cmd.exp_idx[0];
    assign w7       = win_reg[31:0];
    always_comb begin
        if (rot_step) begin
            tmp = {acbc_pkg::FwdSbox[w7[23:16]] ^ rcon_reg, acbc_pkg::FwdSbox[w7[15:8]],
                   acbc_pkg::FwdSbox[w7[7:0]], acbc_pkg::FwdSbox[w7[31:24]]};
        end else begin
            tmp = {acbc_pkg::FwdSbox[w7[31:24]], acbc_pkg::FwdSbox[w7[23:16]],
                   acbc_pkg::FwdSbox[w7[15:8]], acbc_pkg::FwdSbox[w7[7:0]]};
        end
        n0 = win_reg[255:224] ^ tmp;
        n1 = win_reg[223:192] ^ n0;
        n2 = win_reg[191:160] ^ n1;
        n3 = win_reg[159:128] ^ n2;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_reg   <= '{default: '0};
            iv_hi_reg <= '0;
            iv_lo_reg <= '0;
            prev_reg  <= '0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    acbc_pkg::CfgKey0: key_reg[0] <= cfg_data;
                    acbc_pkg::CfgKey1: key_reg[1] <= cfg_data;
                    acbc_pkg::CfgKey2: key_reg[2] <= cfg_data;
                    acbc_pkg::CfgKey3: key_reg[3] <= cfg_data;
                    acbc_pkg::CfgIvHi: iv_hi_reg  <= cfg_data;
                    acbc_pkg::CfgIvLo: iv_lo_reg  <= cfg_data;
                    default: ;
                endcase
            end
            if (cmd.blk_load) begin
                prev_reg <= {s_cipher_high, s_cipher_low};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.exp_load) begin
            win_reg  <= {key_reg[0], key_reg[1], key_reg[2], key_reg[3]};
            rcon_reg <= 8'h01;
        end
        if (cmd.exp_step) begin
            rk_reg[cmd.exp_idx] <= win_reg[255:128];
            win_reg             <= {win_reg[127:0], n0, n1, n2, n3};
            if (rot_step) begin
                rcon_reg <= xt(rcon_reg);
            end
        end
        if (cmd.blk_load) begin
            blk_reg   <= {s_cipher_high, s_cipher_low} ^ rk;
            chain_reg <= s_first_block ? {iv_hi_reg, iv_lo_reg} : prev_reg;
        end
        if (cmd.rnd_step) begin
            blk_reg <= mx;
        end
        if (cmd.out_load) begin
            plain_reg <= ak ^ chain_reg;
        end
    end

    assign m_plain_high = plain_reg[127:64];
    assign m_plain_low  = plain_reg[63:0];

endmodule

// ===== sv/aes256_cbc_decrypt.sv =====
// ----------------------------------------------------------------------------
// aes256_cbc_decrypt
// AES-256 CBC decryption of 128-bit blocks, one inverse round per cycle.
// ----------------------------------------------------------------------------
// Usage:
//   s_* channel: one ciphertext block per request, byte 0 in the top bits.
//     s_first_block chains the block with the IV registers, otherwise with
//     the previous ciphertext block (zero after reset).
//   m_* channel: one plaintext block per request, held in an output register.
//   cfg_* channel: register writes, always ready. Indexes 0-3 are the key
//     words, 4 and 5 the IV halves; other indexes are dropped. Write only
//     while no block is in flight.
//   Timing: an accepted block gets the initial key addition in the accept
//     cycle, then 14 inverse rounds on the single round unit; its result
//     shows on m_valid the cycle after the last round. The next block is
//     taken as soon as the rounds finish, even while the result still waits.
//   Key schedule: after reset and after every key write, the 15 round keys
//     are built after a load step, one round key per cycle; s_ready stays
//     low meanwhile.
//   Stall: if m_ready is low when a new result is due, the last round holds
//     until the output register frees up.
// ----------------------------------------------------------------------------
module aes256_cbc_decrypt (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [acbc_pkg::CfgIdxW-1:0]    cfg_index,
    input  logic [63:0]                     cfg_data,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [63:0]                     s_cipher_high,
    input  logic [63:0]                     s_cipher_low,
    input  logic                            s_first_block,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [63:0]                     m_plain_high,
    output logic [63:0]                     m_plain_low
);

    acbc_pkg::dp_cmd_t cmd;

    // sequencer: owns the state, the counter and the result valid flag
    acbc_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_ready (cfg_ready),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .cmd       (cmd)
    );

    // datapath: registers, key schedule, round key store and round logic
    acbc_dp u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_valid && cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_cipher_high (s_cipher_high),
        .s_cipher_low  (s_cipher_low),
        .s_first_block (s_first_block),
        .m_plain_high  (m_plain_high),
        .m_plain_low   (m_plain_low),
        .cmd           (cmd)
    );

endmodule

// ===== sv/acbc_checker.sv =====
// ----------------------------------------------------------------------------
// acbc_checker
// Port-level checks for the decryption block, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module acbc_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            cfg_valid,
    input logic                            cfg_ready,
    input logic [acbc_pkg::CfgIdxW-1:0]    cfg_index,
    input logic                            s_valid,
    input logic                            s_ready,
    input logic                            m_valid,
    input logic                            m_ready,
    input logic [63:0]                     m_plain_high,
    input logic [63:0]                     m_plain_low
);

    // a stalled result holds
    `ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_plain_high) && $stable(m_plain_low))
    // one block in flight at a time
    `ASSERT_NEXT(a_single_block, aclk, aresetn, s_valid && s_ready, !s_ready)
    // a key write blocks input while the schedule is rebuilt
    `ASSERT_NEXT(a_key_rebuild, aclk, aresetn, cfg_valid && cfg_ready && cfg_index <= acbc_pkg::CfgKey3, !s_ready)
    // reset clears the result and starts the key schedule
    `ASSERT_NEXT_NR(a_reset_state, aclk, !aresetn, !m_valid && !s_ready)

endmodule

bind aes256_cbc_decrypt acbc_checker u_acbc_checker (.*);
